// ----- design/u2u_pkg.sv -----
// types, constants and byte formatting shared by the utf-16 to utf-8 encoder
`timescale 1ns / 1ps

package u2u_pkg;

  localparam logic [15:0] HighFirst = 16'hd800;
  localparam logic [15:0] HighLast  = 16'hdbff;
  localparam logic [15:0] LowFirst  = 16'hdc00;
  localparam logic [15:0] LowLast   = 16'hdfff;
  localparam logic [20:0] SuppBase  = 21'h10000;
  localparam logic [20:0] Max1Byte  = 21'h00007f;
  localparam logic [20:0] Max2Byte  = 21'h0007ff;
  localparam logic [20:0] Max3Byte  = 21'h00ffff;
  localparam logic [7:0]  Lead2     = 8'hc0;
  localparam logic [7:0]  Lead3     = 8'he0;
  localparam logic [7:0]  Lead4     = 8'hf0;
  localparam logic [7:0]  ContMark  = 8'h80;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        end_of_string;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       string_end;
    logic       status;
  } out_req_t;

  typedef enum logic {
    JOB_ENCODE,
    JOB_FAIL
  } job_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    logic [20:0] code_point;
    logic        eos;
  } job_t;

  // index of the final byte of the code point's encoding
  function automatic logic [1:0] last_index(input logic [20:0] cp);
    logic [1:0] idx;
    if (cp <= Max1Byte) begin
      idx = 2'd0;
    end else if (cp <= Max2Byte) begin
      idx = 2'd1;
    end else if (cp <= Max3Byte) begin
      idx = 2'd2;
    end else begin
      idx = 2'd3;
    end
    return idx;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] last,
                                           input logic [1:0] idx);
    logic [7:0] b;
    // position counted back from the final byte
    logic [1:0] back;
    back = last - idx;
    if (last == 2'd0) begin
      b = {1'b0, cp[6:0]};
    end else begin
      case (back)
        2'd0: b = ContMark | {2'b00, cp[5:0]};
        2'd1: b = (last == 2'd1) ? (Lead2 | {3'b000, cp[10:6]})
                                 : (ContMark | {2'b00, cp[11:6]});
        2'd2: b = (last == 2'd2) ? (Lead3 | {4'b0000, cp[15:12]})
                                 : (ContMark | {2'b00, cp[17:12]});
        2'd3: b = Lead4 | {5'b00000, cp[20:18]};
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

endpackage

// ----- design/u2u_front.sv -----
// front end: classifies code units, pairs surrogates and tracks string errors
`timescale 1ns / 1ps

module u2u_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  u2u_pkg::in_req_t in_req_i,
  input  logic            q_full_i,
  output logic            push_o,
  output u2u_pkg::job_t   push_job_o
);
  import u2u_pkg::*;

  logic       pending_q, pending_d;
  logic [9:0] high_bits_q, high_bits_d;
  logic       failed_q, failed_d;
  logic       accept;
  logic       is_high, is_low;
  logic [15:0] unit;
  logic       eos;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign unit       = in_req_i.code_unit;
  assign eos        = in_req_i.end_of_string;
  assign is_high    = unit inside {[HighFirst:HighLast]};
  assign is_low     = unit inside {[LowFirst:LowLast]};

  always_comb begin
    pending_d   = pending_q;
    high_bits_d = high_bits_q;
    failed_d    = failed_q;
    push_o      = 1'b0;
    push_job_o.kind       = JOB_ENCODE;
    push_job_o.code_point = {5'd0, unit};
    push_job_o.eos        = eos;
    if (accept) begin
      if (failed_q) begin
        // swallow until end of string
        push_o = eos;
        push_job_o.kind = JOB_FAIL;
      end else if (pending_q) begin
        if (is_low) begin
          push_o = 1'b1;
          push_job_o.code_point = SuppBase + {1'b0, high_bits_q, unit[9:0]};
          pending_d   = 1'b0;
          high_bits_d = 10'd0;
        end else begin
          push_o = eos;
          push_job_o.kind = JOB_FAIL;
          failed_d    = !eos;
          pending_d   = 1'b0;
          high_bits_d = 10'd0;
        end
      end else if (is_high) begin
        if (eos) begin
          push_o = 1'b1;
          push_job_o.kind = JOB_FAIL;
        end else begin
          pending_d   = 1'b1;
          high_bits_d = unit[9:0];
        end
      end else if (is_low) begin
        push_o = eos;
        push_job_o.kind = JOB_FAIL;
        failed_d = !eos;
      end else begin
        push_o = 1'b1;
      end
      if (eos) begin
        pending_d   = 1'b0;
        high_bits_d = 10'd0;
        failed_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= 1'b0;
      high_bits_q <= 10'd0;
      failed_q    <= 1'b0;
    end else begin
      pending_q   <= pending_d;
      high_bits_q <= high_bits_d;
      failed_q    <= failed_d;
    end
  end

endmodule

// ----- design/u2u_fifo.sv -----
// short job queue between the front and back ends
`timescale 1ns / 1ps

module u2u_fifo #(
  parameter int Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  u2u_pkg::job_t push_job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output u2u_pkg::job_t head_o
);
  import u2u_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ----- design/u2u_back.sv -----
// back end: serializes jobs into utf-8 bytes or a fail status through an output register
`timescale 1ns / 1ps

module u2u_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  u2u_pkg::job_t    head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output u2u_pkg::out_req_t out_req_o
);
  import u2u_pkg::*;

  logic       out_valid_q, out_valid_d;
  out_req_t   out_q, out_d;
  logic [1:0] idx_q, idx_d;
  logic [1:0] last;
  logic       load;
  logic       final_byte;

  assign last       = last_index(head_i.code_point);
  assign load       = !q_empty_i && (!out_valid_q || out_ready_i);
  assign final_byte = (head_i.kind == JOB_FAIL) || (idx_q == last);
  assign pop_o      = load && final_byte;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    idx_d       = idx_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      if (head_i.kind == JOB_FAIL) begin
        out_d.out_byte    = 8'h00;
        out_d.byte_valid  = 1'b0;
        out_d.last_of_run = 1'b1;
        out_d.string_end  = 1'b1;
        out_d.status      = 1'b1;
      end else begin
        out_d.out_byte    = utf8_byte(head_i.code_point, last, idx_q);
        out_d.byte_valid  = 1'b1;
        out_d.last_of_run = final_byte;
        out_d.string_end  = final_byte && head_i.eos;
        out_d.status      = 1'b0;
      end
      idx_d = final_byte ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

// ----- design/utf16_to_utf8_encoder_unit.sv -----
// utf-16 to utf-8 encoder top level: front end, job queue, byte serializer
// a unit's job is written into the job queue, and its first byte is loaded into the back end's output register
// throughput: one byte per cycle while out_ready_i is high, set by the back end's output register;
//   ascii units give 1 byte, bmp units up to 3 bytes, surrogate pairs 4 bytes per pair
// the front keeps accepting while the job queue has room
// reset clears surrogate/error state, the queue and the output valid
`timescale 1ns / 1ps

module utf16_to_utf8_encoder_unit #(
  parameter int QueueDepth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  u2u_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output u2u_pkg::out_req_t out_req_o
);
  import u2u_pkg::*;

  logic q_full, q_empty, push, pop;
  job_t push_job, head;

  u2u_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_job_o (push_job)
  );

  u2u_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .head_o     (head)
  );

  u2u_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

endmodule
